// File: rtl/imadec_pkg.sv
// imadec_pkg: shared types, constants and the standard IMA step and index tables
// used by the ADPCM nibble decoder modules; no dependencies
package imadec_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int IDX_W     = 7;
	localparam int STEP_W    = 15;
	localparam int NIBBLE_W  = 4;
	localparam int HIDX_W    = 8;

	localparam logic [IDX_W-1:0] MAX_INDEX = 7'd88;

	// input item kinds
	localparam logic MODE_HEADER = 1'b0;
	localparam logic MODE_NIBBLE = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [IDX_W-1:0]           idx_t;
	typedef logic [STEP_W-1:0]          step_t;

	// predictor state write, one channel per cycle
	typedef struct packed {
		logic    we;
		logic    [2:0] ch;
		sample_t pred;
		idx_t    idx;
	} upd_t;

	// step size for a step index 0..88
	function automatic step_t step_size(input idx_t idx);
		step_t s;
		unique case (idx)
			7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;     7'd3:  s = 15'd10;
			7'd4:  s = 15'd11;    7'd5:  s = 15'd12;    7'd6:  s = 15'd13;    7'd7:  s = 15'd14;
			7'd8:  s = 15'd16;    7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
			7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;    7'd15: s = 15'd31;
			7'd16: s = 15'd34;    7'd17: s = 15'd37;    7'd18: s = 15'd41;    7'd19: s = 15'd45;
			7'd20: s = 15'd50;    7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
			7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;    7'd27: s = 15'd97;
			7'd28: s = 15'd107;   7'd29: s = 15'd118;   7'd30: s = 15'd130;   7'd31: s = 15'd143;
			7'd32: s = 15'd157;   7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
			7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;   7'd39: s = 15'd307;
			7'd40: s = 15'd337;   7'd41: s = 15'd371;   7'd42: s = 15'd408;   7'd43: s = 15'd449;
			7'd44: s = 15'd494;   7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
			7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;   7'd51: s = 15'd963;
			7'd52: s = 15'd1060;  7'd53: s = 15'd1166;  7'd54: s = 15'd1282;  7'd55: s = 15'd1411;
			7'd56: s = 15'd1552;  7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
			7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;  7'd63: s = 15'd3024;
			7'd64: s = 15'd3327;  7'd65: s = 15'd3660;  7'd66: s = 15'd4026;  7'd67: s = 15'd4428;
			7'd68: s = 15'd4871;  7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
			7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;  7'd75: s = 15'd9493;
			7'd76: s = 15'd10442; 7'd77: s = 15'd11487; 7'd78: s = 15'd12635; 7'd79: s = 15'd13899;
			7'd80: s = 15'd15289; 7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
			7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086; 7'd87: s = 15'd29794;
			default: s = 15'd32767;
		endcase
		return s;
	endfunction

	// step index adjustment from the magnitude bits
	function automatic logic signed [7:0] index_adjust(input logic [2:0] mag);
		logic signed [7:0] a;
		unique case (mag)
			3'd4:    a = 8'sd2;
			3'd5:    a = 8'sd4;
			3'd6:    a = 8'sd6;
			3'd7:    a = 8'sd8;
			default: a = -8'sd1;
		endcase
		return a;
	endfunction

endpackage

// File: rtl/imadec_state.sv
// imadec_state: per-channel predictor sample and step index registers
// depends on imadec_pkg
module imadec_state
	import imadec_pkg::*;
#(
	parameter int CHANNELS = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    [2:0] rd_ch,
	output sample_t rd_pred,
	output idx_t    rd_idx,
	input  upd_t    upd
);

	sample_t pred_q [CHANNELS];
	idx_t    idx_q  [CHANNELS];

	// read port, zero for a channel that does not exist
	always_comb begin
		rd_pred = '0;
		rd_idx  = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (rd_ch == 3'(c)) begin
				rd_pred = pred_q[c];
				rd_idx  = idx_q[c];
			end
		end
	end

	// write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pred_q[c] <= '0;
				idx_q[c]  <= '0;
			end
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (upd.we && upd.ch == 3'(c)) begin
					pred_q[c] <= upd.pred;
					idx_q[c]  <= upd.idx;
				end
			end
		end
	end

endmodule

// File: rtl/imadec_step.sv
// imadec_step: one IMA ADPCM nibble update of predictor and step index
// depends on imadec_pkg
module imadec_step
	import imadec_pkg::*;
(
	input  sample_t pred,
	input  idx_t    idx,
	input  logic    [NIBBLE_W-1:0] code,
	output sample_t new_pred,
	output idx_t    new_idx
);

	step_t                    step;
	logic [SAMPLE_W-1:0]      diff;
	logic signed [SAMPLE_W+1:0] sum;
	logic signed [SAMPLE_W+1:0] delta;
	logic signed [7:0]        nidx;

	// difference from the magnitude bits, each term truncated on its own
	always_comb begin
		step = step_size(idx);
		diff = 16'(step >> 3);
		if (code[2]) diff = diff + 16'(step);
		if (code[1]) diff = diff + 16'(step >> 1);
		if (code[0]) diff = diff + 16'(step >> 2);
	end

	// signed add with saturation to 16 bits
	always_comb begin
		delta = $signed({2'b00, diff});
		if (code[3]) delta = -delta;
		sum = $signed({{2{pred[SAMPLE_W-1]}}, pred}) + delta;
		if (sum > 18'sd32767)
			new_pred = 16'sh7fff;
		else if (sum < -18'sd32768)
			new_pred = 16'sh8000;
		else
			new_pred = sum[SAMPLE_W-1:0];
	end

	// index adaptation with clamp to 0..88
	always_comb begin
		nidx = $signed({1'b0, idx}) + index_adjust(code[2:0]);
		if (nidx < 8'sd0)
			new_idx = '0;
		else if (nidx > $signed({1'b0, MAX_INDEX}))
			new_idx = MAX_INDEX;
		else
			new_idx = nidx[IDX_W-1:0];
	end

endmodule

// File: rtl/ima_adpcm_nibble_decoder.sv
// ima_adpcm_nibble_decoder: top level of the IMA ADPCM decoder with per-channel predictors
// depends on imadec_pkg, imadec_state, imadec_step
//
//  channel | direction | tdata (low bit up)                              | tuser (low bit up)
//  s_*     | in        | nibble[3:0] header_sample[19:4] header_index[27:20] | mode[0] channel[1]
//  m_*     | out       | sample[15:0]                                     | -
//
// one item per clock sustained while the output is not stalled; a taken item goes into the input register,
// which feeds a single pass of table lookup, add and clamp into the output register
// channel state is written as the item moves to the output, so the next item sees it at once
// reset clears both predictors and step indexes and empties the pipeline
// a stalled output register holds its item; the input register keeps taking items while it is free
module ima_adpcm_nibble_decoder
	import imadec_pkg::*;
#(
	parameter int CHANNELS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // nibble, header_sample, header_index, zero pad
	input  logic [1:0]  s_tuser,   // mode, channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // sample
);

	logic                valid_s1;
	logic                mode_s1;
	logic                chan_s1;
	logic [NIBBLE_W-1:0] nib_s1;
	sample_t             hsamp_s1;
	logic [HIDX_W-1:0]   hidx_s1;

	logic    out_valid_q;
	sample_t sample_q;

	logic    advance;
	logic    ch_ok;
	sample_t st_pred;
	idx_t    st_idx;
	sample_t nib_pred;
	idx_t    nib_idx;
	idx_t    hdr_idx;
	sample_t result;
	upd_t    upd;

	// handshake
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = sample_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1  <= s_tuser[0];
			chan_s1  <= s_tuser[1];
			nib_s1   <= s_tdata[3:0];
			hsamp_s1 <= s_tdata[19:4];
			hidx_s1  <= s_tdata[27:20];
		end
	end

	assign ch_ok = 32'(chan_s1) < CHANNELS;

	imadec_state #(.CHANNELS(CHANNELS)) u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_ch   (3'(chan_s1)),
		.rd_pred (st_pred),
		.rd_idx  (st_idx),
		.upd     (upd)
	);

	imadec_step u_step (
		.pred     (st_pred),
		.idx      (st_idx),
		.code     (nib_s1),
		.new_pred (nib_pred),
		.new_idx  (nib_idx)
	);

	// header index clamp
	assign hdr_idx = (hidx_s1 > {1'b0, MAX_INDEX}) ? MAX_INDEX : hidx_s1[IDX_W-1:0];

	// result and state update select
	always_comb begin
		upd.ch = 3'(chan_s1);
		upd.we = advance && ch_ok;
		if (mode_s1 == MODE_HEADER) begin
			result   = hsamp_s1;
			upd.pred = hsamp_s1;
			upd.idx  = hdr_idx;
		end else begin
			result   = ch_ok ? nib_pred : '0;
			upd.pred = nib_pred;
			upd.idx  = nib_idx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_q <= result;
		end
	end

endmodule

// File: rtl/imadec_checker.sv
// imadec_checker: port-level checks of the decoder's flow control, bound to the top level
// depends on ima_adpcm_nibble_decoder ports only
module imadec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// with the output empty the input side never blocks
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	// a result taken frees the input side in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |-> s_tready)
		else $error("input blocked while result drains");

	// a fresh result comes from an item taken into the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a matching item");

endmodule

bind ima_adpcm_nibble_decoder imadec_checker u_imadec_checker (.*);

// File: dv/ima_adpcm_nibble_decoder_checker.sv
// ima_adpcm_nibble_decoder_checker: watches both streams of the decoder, predicts every
// sample from its own per-channel state and compares in order
// depends on imadec_pkg for the sample and index types, the item kinds and the index limit
`timescale 1ns / 1ps

module ima_adpcm_nibble_decoder_checker
	import imadec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // nibble, header_sample, header_index, zero pad
	input  logic [1:0]  s_tuser,   // mode, channel
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // sample
	output int          mismatches,
	output int          pending,
	output int          clips
);

	localparam int PCM_MAX = 32767;
	localparam int PCM_MIN = -32768;

	// standard IMA step sizes by step index
	localparam int STEP_TAB [89] = '{
		7, 8, 9, 10, 11, 12, 13, 14, 16, 17, 19, 21, 23, 25, 28, 31,
		34, 37, 41, 45, 50, 55, 60, 66, 73, 80, 88, 97, 107, 118, 130, 143,
		157, 173, 190, 209, 230, 253, 279, 307, 337, 371, 408, 449, 494, 544, 598, 658,
		724, 796, 876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066, 2272, 2499,
		2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358, 5894, 6484, 7132, 7845, 8630,
		9493, 10442, 11487, 12635, 13899, 15289, 16818, 18500, 20350, 22385, 24623,
		27086, 29794, 32767
	};

	typedef struct {
		int      seq;
		sample_t pcm;
	} due_t;

	due_t    due_samples[$];
	sample_t chan_pred [2];
	idx_t    chan_idx [2];
	int      n_taken;
	int      n_bad;
	int      n_clip;

	// one nibble step: new sample, new step index and whether the sum saturated
	function automatic sample_t adpcm_next(input sample_t prev, input idx_t idx,
			input logic [3:0] code, output idx_t idx_next, output logic clipped);
		int step;
		int delta;
		int acc;
		int mag;
		int ni;
		step  = STEP_TAB[idx];
		delta = step >>> 3;
		if (code[2]) delta += step;
		if (code[1]) delta += step >>> 1;
		if (code[0]) delta += step >>> 2;
		if (code[3]) delta = -delta;
		acc     = int'(prev) + delta;
		clipped = 1'b0;
		if (acc > PCM_MAX) begin
			acc     = PCM_MAX;
			clipped = 1'b1;
		end else if (acc < PCM_MIN) begin
			acc     = PCM_MIN;
			clipped = 1'b1;
		end
		// small codes back the index off by one, large ones push it up in steps of two
		mag = int'(code[2:0]);
		ni  = int'(idx) + (mag < 4 ? -1 : 2 * (mag - 3));
		if (ni < 0) ni = 0;
		else if (ni > int'(MAX_INDEX)) ni = int'(MAX_INDEX);
		idx_next = idx_t'(ni);
		return sample_t'(acc);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		due_t       want;
		due_t       got_item;
		logic       kind;
		logic       ch;
		logic [7:0] hidx;
		idx_t       nidx;
		logic       clipped;
		if (!arst_n) begin
			due_samples.delete();
			chan_pred[0] = '0;
			chan_pred[1] = '0;
			chan_idx[0]  = '0;
			chan_idx[1]  = '0;
			n_taken      = 0;
			n_bad        = 0;
			n_clip       = 0;
			mismatches  <= 0;
			pending     <= 0;
			clips       <= 0;
		end else begin
			// outgoing sample against the oldest prediction
			if (m_tvalid && m_tready) begin
				if (due_samples.size() == 0) begin
					if (n_bad < 10)
						$display("unexpected sample %0d with nothing outstanding",
							$signed(m_tdata));
					n_bad++;
				end else begin
					want = due_samples.pop_front();
					if (m_tdata !== want.pcm) begin
						if (n_bad < 10)
							$display("sample mismatch on item %0d: expected %0d, got %0d",
								want.seq, want.pcm, $signed(m_tdata));
						n_bad++;
					end
				end
			end
			// incoming item updates the channel model
			if (s_tvalid && s_tready) begin
				kind = s_tuser[0];
				ch   = s_tuser[1];
				got_item.seq = n_taken;
				if (kind == MODE_HEADER) begin
					hidx = s_tdata[27:20];
					chan_pred[ch] = sample_t'(s_tdata[19:4]);
					chan_idx[ch]  = (hidx > 8'(MAX_INDEX)) ? MAX_INDEX : idx_t'(hidx);
					got_item.pcm  = sample_t'(s_tdata[19:4]);
				end else begin
					got_item.pcm  = adpcm_next(chan_pred[ch], chan_idx[ch], s_tdata[3:0],
						nidx, clipped);
					chan_pred[ch] = got_item.pcm;
					chan_idx[ch]  = nidx;
					if (clipped) n_clip++;
				end
				due_samples.push_back(got_item);
				n_taken++;
			end
			mismatches <= n_bad;
			pending    <= due_samples.size();
			clips      <= n_clip;
		end
	end

endmodule

// File: dv/ima_adpcm_nibble_decoder_test.sv
// ima_adpcm_nibble_decoder_test: stimulus and verdict for the IMA ADPCM nibble decoder;
// directed edge cases, then header-led runs of nibbles with random gaps and stalls
// depends on imadec_pkg, ima_adpcm_nibble_decoder and ima_adpcm_nibble_decoder_checker
`timescale 1ns / 1ps

module ima_adpcm_nibble_decoder_test
	import imadec_pkg::*;
();

	localparam int RANDOM_ITEMS = 1450;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	int   mismatches;
	int   pending;
	int   clips;
	int   n_headers;
	int   n_nibbles;
	int   stall_left = 0;
	bit   quiet;

	ima_adpcm_nibble_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ima_adpcm_nibble_decoder_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending),
		.clips      (clips)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// output stalls: mostly short, a few long, none started while quiet
	always @(posedge clk) begin : sink
		int r;
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (!quiet) begin
				r = $urandom_range(0, 99);
				if (r < 4) stall_left <= $urandom_range(8, 40);
				else if (r < 20) stall_left <= $urandom_range(1, 3);
			end
		end
	end

	// header sample, pinned to full scale now and then
	function automatic logic [15:0] pick_sample();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 16'h7fff;
		if (r == 1) return 16'h8000;
		return 16'($urandom);
	endfunction

	// present one item, wait for the handshake, then maybe idle
	task automatic put_item(input logic kind, input logic ch, input logic [3:0] code,
			input logic [15:0] hsample, input logic [7:0] hidx);
		int r;
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, hidx, hsample, code};
		s_tuser  <= {ch, kind};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (kind == MODE_HEADER) n_headers++;
		else n_nibbles++;
		if (!quiet) begin
			r   = $urandom_range(0, 99);
			gap = (r < 65) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold the input until every predicted sample has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int   sent;
		int   run_len;
		bit   stereo;
		bit   loud;
		bit   paused;
		logic ch;
		logic [3:0] code;
		quiet      = 1'b0;
		n_headers  = 0;
		n_nibbles  = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full scale headers, out of range index, saturation both ways
		put_item(MODE_HEADER, 1'b0, 4'hf, 16'h7fff, 8'hff);
		put_item(MODE_NIBBLE, 1'b0, 4'h7, 16'hffff, 8'hff);
		put_item(MODE_HEADER, 1'b1, 4'h0, 16'h8000, 8'd88);
		put_item(MODE_NIBBLE, 1'b1, 4'hf, 16'h0000, 8'h00);
		put_item(MODE_HEADER, 1'b1, 4'h5, 16'h1234, 8'd89);
		// index climbing past the top
		put_item(MODE_HEADER, 1'b1, 4'ha, 16'h0000, 8'd87);
		put_item(MODE_NIBBLE, 1'b1, 4'h7, 16'haaaa, 8'h55);
		// every code in turn after a header at the bottom index; the small codes back off below zero
		put_item(MODE_HEADER, 1'b0, 4'h3, 16'h0000, 8'd0);
		for (int c = 0; c < 16; c++)
			put_item(MODE_NIBBLE, 1'b0, 4'(c), 16'($urandom), 8'($urandom));
		drain();

		// header-led runs, mono or stereo, with stray items mixed in
		sent   = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			quiet   = ($urandom_range(0, 5) == 0);
			stereo  = 1'($urandom_range(0, 1));
			loud    = ($urandom_range(0, 3) == 0);
			ch      = 1'($urandom_range(0, 1));
			run_len = $urandom_range(8, 64);
			put_item(MODE_HEADER, ch, 4'($urandom), pick_sample(),
				($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 88)));
			sent++;
			if (stereo) begin
				put_item(MODE_HEADER, !ch, 4'($urandom), pick_sample(),
					8'($urandom_range(0, 88)));
				sent++;
			end
			for (int k = 0; k < run_len; k++) begin
				if ($urandom_range(0, 19) == 0) begin
					put_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						4'($urandom), pick_sample(), 8'($urandom));
				end else begin
					code = 4'($urandom);
					// loud runs drive the index up and the sample into the rails
					if (loud && $urandom_range(0, 3) != 0) code[2] = 1'b1;
					put_item(MODE_NIBBLE, stereo ? logic'(k % 2) ^ ch : ch, code,
						16'($urandom), 8'($urandom));
				end
				sent++;
			end
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				drain();
				paused = 1'b1;
			end
		end
		quiet = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		$display("covered %0d header items and %0d nibble items over both channels",
			n_headers, n_nibbles);
		$display("%0d decoded samples saturated at the 16-bit limits", clips);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
